[rtl/console_line_editing_buffer_assert.svh]
// Assertion macros for the console line editing buffer checker.
// Needs a clk and an arst_n in the scope where they are used.
`ifndef CONSOLE_LINE_EDITING_BUFFER_ASSERT_SVH
`define CONSOLE_LINE_EDITING_BUFFER_ASSERT_SVH

// ante holds in this cycle -> cons holds in the same cycle
`define CLEB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// ante holds in this cycle -> cons holds in the next cycle
`define CLEB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/cleb_pkg.sv]
// Shared types and codes for the console line editing buffer.
// No dependencies.
`timescale 1ns / 1ps

package cleb_pkg;

	localparam int BUF_DEPTH_DEF = 128;

	// key codes
	localparam logic [7:0] KEY_DUMP = 8'h10;
	localparam logic [7:0] KEY_KILL = 8'h15;
	localparam logic [7:0] KEY_BS   = 8'h08;
	localparam logic [7:0] KEY_DEL  = 8'h7F;
	localparam logic [7:0] KEY_EOF  = 8'h04;
	localparam logic [7:0] KEY_CR   = 8'h0D;
	localparam logic [7:0] KEY_LF   = 8'h0A;
	localparam logic [7:0] KEY_NUL  = 8'h00;

	// item op codes
	localparam logic OP_KEY  = 1'b0;
	localparam logic OP_READ = 1'b1;

	// echo kinds
	localparam logic [1:0] ECHO_NONE  = 2'd0;
	localparam logic [1:0] ECHO_CHAR  = 2'd1;
	localparam logic [1:0] ECHO_ERASE = 2'd2;

	// read status codes
	localparam logic [2:0] RD_NONE    = 3'd0;
	localparam logic [2:0] RD_CHAR    = 3'd1;
	localparam logic [2:0] RD_NEWLINE = 3'd2;
	localparam logic [2:0] RD_EOF     = 3'd3;
	localparam logic [2:0] RD_EMPTY   = 3'd4;

	localparam logic [7:0] CNT_MAX = 8'hFF;

	typedef struct packed {
		logic       op;
		logic [7:0] key_char;
		logic       first_of_read;
	} item_t;

	typedef struct packed {
		logic [1:0] echo_kind;
		logic [7:0] echo_char;
		logic [7:0] erase_count;
		logic       line_committed;
		logic       dump_request;
		logic [2:0] read_status;
		logic [7:0] read_char;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_KILL,
		ST_READ,
		ST_OUT
	} state_t;

endpackage

[rtl/cleb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module cleb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/console_line_editing_buffer.sv]
// Top level of the console line editing buffer: sequencer, index unit and store.
// Depends on cleb_pkg and cleb_ram.
`timescale 1ns / 1ps

// Canonical console line editor over a ring buffer of BUF_DEPTH characters.
// Issue an item with start while busy is low; its single result appears on
// result for exactly one cycle with done high, and the receiver cannot stall
// it. A key item passes through EXEC and then OUT; a read item through EXEC,
// READ and OUT, skipping READ when nothing is committed; Ctrl-U stays in KILL
// while it erases, because the backward walk reads one store entry per cycle
// through the single read port of the line store, and then goes to OUT.
// busy stays high from the accepting edge until the done cycle ends. No
// clearing pass after reset: only entries between the read and edit indices
// are ever read, and they have always been written.
module console_line_editing_buffer
	import cleb_pkg::*;
#(
	parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    done,
	output result_t result
);

	// indices run modulo twice the depth, so full and empty differ
	localparam int IW = $clog2(2 * BUF_DEPTH);
	localparam int AW = $clog2(BUF_DEPTH);
	localparam logic [IW-1:0] IDX_LAST = IW'(2 * BUF_DEPTH - 1);
	localparam logic [IW-1:0] DEPTH_I  = IW'(BUF_DEPTH);
	localparam logic [IW:0]   MOD_W    = (IW + 1)'(2 * BUF_DEPTH);
	localparam logic [IW:0]   DEPTH_W  = (IW + 1)'(BUF_DEPTH);

	function automatic logic [IW-1:0] idx_next(input logic [IW-1:0] x);
		return (x == IDX_LAST) ? '0 : x + 1'b1;
	endfunction

	function automatic logic [IW-1:0] idx_prev(input logic [IW-1:0] x);
		return (x == '0) ? IDX_LAST : x - 1'b1;
	endfunction

	function automatic logic [AW-1:0] slot(input logic [IW-1:0] x);
		logic [IW-1:0] s;
		s = (x >= DEPTH_I) ? x - DEPTH_I : x;
		return s[AW-1:0];
	endfunction

	function automatic logic [IW:0] idx_dist(input logic [IW-1:0] a, input logic [IW-1:0] b);
		logic [IW:0] d;
		d = {1'b0, a} - {1'b0, b};
		return (a < b) ? d + MOD_W : d;
	endfunction

	state_t        state_q, state_d;
	logic [IW-1:0] read_q, read_d;
	logic [IW-1:0] commit_q, commit_d;
	logic [IW-1:0] edit_q, edit_d;
	item_t         item_q;
	result_t       res_q, res_d;

	// line store port signals
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	// index unit outputs, shared by the EXEC, KILL and READ states
	logic [IW-1:0] edit_prev, edit_prev2, edit_next, read_next;
	logic [7:0]    key_mapped;
	logic          has_room, fills_up;

	assign edit_prev  = idx_prev(edit_q);
	assign edit_prev2 = idx_prev(edit_prev);
	assign edit_next  = idx_next(edit_q);
	assign read_next  = idx_next(read_q);
	assign has_room   = idx_dist(edit_q, read_q) < DEPTH_W;
	assign fills_up   = idx_dist(edit_next, read_q) == DEPTH_W;
	assign key_mapped = (item_q.key_char == KEY_CR) ? KEY_LF : item_q.key_char;

	cleb_ram #(
		.WIDTH (8),
		.DEPTH (BUF_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			read_q   <= '0;
			commit_q <= '0;
			edit_q   <= '0;
		end else begin
			state_q  <= state_d;
			read_q   <= read_d;
			commit_q <= commit_d;
			edit_q   <= edit_d;
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_q <= item;
		end
		res_q <= res_d;
	end

	always_comb begin
		state_d   = state_q;
		read_d    = read_q;
		commit_d  = commit_q;
		edit_d    = edit_q;
		res_d     = res_q;
		ram_we    = 1'b0;
		ram_waddr = slot(edit_q);
		ram_wdata = key_mapped;
		ram_raddr = slot(read_q);

		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end

			ST_EXEC: begin
				res_d   = '0;
				state_d = ST_OUT;
				if (item_q.op == OP_READ) begin
					if (read_q == commit_q) begin
						res_d.read_status = RD_EMPTY;
					end else begin
						// store read at slot(read) issued above
						state_d = ST_READ;
					end
				end else begin
					case (item_q.key_char)
						KEY_DUMP: begin
							res_d.dump_request = 1'b1;
						end
						KEY_KILL: begin
							if (edit_q != commit_q) begin
								ram_raddr = slot(edit_prev);
								state_d   = ST_KILL;
							end
						end
						KEY_BS, KEY_DEL: begin
							if (edit_q != commit_q) begin
								edit_d            = edit_prev;
								res_d.echo_kind   = ECHO_ERASE;
								res_d.erase_count = 8'd1;
							end
						end
						KEY_NUL: begin
						end
						default: begin
							if (has_room) begin
								ram_we          = 1'b1;
								edit_d          = edit_next;
								res_d.echo_kind = ECHO_CHAR;
								res_d.echo_char = key_mapped;
								if (key_mapped inside {KEY_LF, KEY_EOF} || fills_up) begin
									commit_d             = edit_next;
									res_d.line_committed = 1'b1;
								end
							end
						end
					endcase
				end
			end

			// ram_rdata holds the entry just before edit
			ST_KILL: begin
				if (ram_rdata == KEY_LF) begin
					state_d = ST_OUT;
				end else begin
					edit_d          = edit_prev;
					res_d.echo_kind = ECHO_ERASE;
					if (res_q.erase_count != CNT_MAX) begin
						res_d.erase_count = res_q.erase_count + 8'd1;
					end
					if (edit_prev == commit_q) begin
						state_d = ST_OUT;
					end else begin
						// fetch the next entry back while this one retires
						ram_raddr = slot(edit_prev2);
					end
				end
			end

			ST_READ: begin
				state_d = ST_OUT;
				if (ram_rdata == KEY_EOF) begin
					res_d.read_status = RD_EOF;
					if (item_q.first_of_read) begin
						read_d = read_next;
					end
				end else begin
					read_d            = read_next;
					res_d.read_char   = ram_rdata;
					res_d.read_status = (ram_rdata == KEY_LF) ? RD_NEWLINE : RD_CHAR;
				end
			end

			ST_OUT: begin
				state_d = ST_IDLE;
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = (state_q == ST_OUT);
	assign result = res_q;

endmodule

[rtl/cleb_checker.sv]
// Port-level checker for the console line editing buffer, bound to the top level.
// Depends on cleb_pkg and console_line_editing_buffer_assert.svh.
`timescale 1ns / 1ps
`include "console_line_editing_buffer_assert.svh"

module cleb_checker
	import cleb_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input item_t   item,
	input logic    done,
	input result_t result
);

	logic accept;

	assign accept = start && !busy;

	`CLEB_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted item did not raise busy")
	`CLEB_ASSERT_NOW(a_done_busy, done, busy, "result strobe outside a busy period")
	`CLEB_ASSERT_NEXT(a_done_single, done, !done && !busy, "result strobe not a single cycle")
	`CLEB_ASSERT_NOW(a_fell_after_done, $fell(busy), $past(done), "busy dropped without a result")
	`CLEB_ASSERT_NOW(a_read_no_echo, done && (result.read_status != RD_NONE), (result.echo_kind == ECHO_NONE) && !result.line_committed && !result.dump_request, "read result carries key effects")

endmodule

bind console_line_editing_buffer cleb_checker u_cleb_checker (.*);
